// ----- hdl/key_value_header_parser_macros.svh -----
// Assertion macros for the key/value header parser.
`ifndef KEY_VALUE_HEADER_PARSER_MACROS_SVH
`define KEY_VALUE_HEADER_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// Checked on clk_i, switched off while rst_ni is low.
`define KVHP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("kvhp assertion failed");
// Checked on clk_i at every edge, reset included.
`define KVHP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("kvhp assertion failed");
`else
`define KVHP_ASSERT(lbl, prop)
`define KVHP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- hdl/kvhp_pkg.sv -----
// Shared types and widths for the key/value header parser.
package kvhp_pkg;

  localparam int unsigned PosW      = 21;
  localparam int unsigned MaxLength = 1048576;   // byte position saturates here

  typedef struct packed {
    logic [7:0]  action_char;
    logic [31:0] format_code;
    logic [31:0] width_pixels;
    logic [31:0] height_pixels;
    logic [31:0] image_number;
    logic [31:0] more_chunks;
    logic        zlib_flag;
    logic [31:0] quiet_level;
    logic [31:0] virtual_place;
    logic [31:0] place_columns;
    logic [31:0] place_rows;
  } params_t;

  typedef struct packed {
    params_t         params;
    logic [PosW-1:0] payload_start;
  } result_t;

endpackage

// ----- hdl/kvhp_parser.sv -----
// Header byte parser: phase machine, value accumulator and parameter record.
module kvhp_parser
  import kvhp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_valid_i,
  input  logic [7:0] step_byte_i,
  input  logic    step_last_i,
  output logic    rec_valid_o,
  output result_t rec_o
);

  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChZ     = 8'h7A;
  localparam logic [7:0] KeyA    = 8'h61;
  localparam logic [7:0] KeyF    = 8'h66;
  localparam logic [7:0] KeyS    = 8'h73;
  localparam logic [7:0] KeyV    = 8'h76;
  localparam logic [7:0] KeyI    = 8'h69;
  localparam logic [7:0] KeyM    = 8'h6D;
  localparam logic [7:0] KeyO    = 8'h6F;
  localparam logic [7:0] KeyQ    = 8'h71;
  localparam logic [7:0] KeyBigU = 8'h55;
  localparam logic [7:0] KeyC    = 8'h63;
  localparam logic [7:0] KeyR    = 8'h72;

  localparam logic [PosW-1:0] MaxPos = PosW'(MaxLength);

  typedef enum logic [1:0] {
    PH_KEY,
    PH_EQ,
    PH_VAL,
    PH_SKIP
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      key_q, key_d;
  logic [31:0]     acc_q, acc_d;
  logic [7:0]      first_q, first_d;
  logic            nonempty_q, nonempty_d;
  logic [PosW-1:0] pos_q, pos_d;
  params_t         rec_q, rec_d;

  logic            done, commit, emit;
  params_t         rec_commit;
  logic [PosW-1:0] pos_next;

  // Writes the finished value into the field its key selects.
  function automatic params_t apply_value(params_t p, logic [7:0] key,
                                          logic [31:0] v, logic [7:0] first);
    params_t r;
    r = p;
    unique case (key)
      KeyA:    r.action_char   = first;
      KeyF:    r.format_code   = v;
      KeyS:    r.width_pixels  = v;
      KeyV:    r.height_pixels = v;
      KeyI:    r.image_number  = v;
      KeyM:    r.more_chunks   = v;
      KeyO:    r.zlib_flag     = (first == ChZ);
      KeyQ:    r.quiet_level   = v;
      KeyBigU: r.virtual_place = v;
      KeyC:    r.place_columns = v;
      KeyR:    r.place_rows    = v;
      default: r = p;
    endcase
    return r;
  endfunction

  always_comb begin
    phase_d    = phase_q;
    key_d      = key_q;
    acc_d      = acc_q;
    first_d    = first_q;
    nonempty_d = nonempty_q;
    pos_d      = pos_q;
    done       = 1'b0;
    commit     = 1'b0;
    pos_next   = (pos_q < MaxPos) ? pos_q + PosW'(1) : pos_q;

    if (step_valid_i && phase_q != PH_SKIP) begin
      pos_d = pos_next;
      unique case (phase_q)
        PH_KEY: begin
          if (step_byte_i == ChSemi) begin
            done = 1'b1;
          end else begin
            key_d   = step_byte_i;
            phase_d = PH_EQ;
          end
        end
        PH_EQ: begin
          if (step_byte_i == ChEq) begin
            phase_d    = PH_VAL;
            acc_d      = '0;
            first_d    = '0;
            nonempty_d = 1'b0;
          end else if (step_byte_i == ChComma) begin
            phase_d = PH_KEY;
          end else if (step_byte_i == ChSemi) begin
            done = 1'b1;
          end else begin
            key_d = step_byte_i;
          end
        end
        PH_VAL: begin
          if (step_byte_i == ChComma) begin
            commit  = 1'b1;
            phase_d = PH_KEY;
          end else if (step_byte_i == ChSemi) begin
            commit = 1'b1;
            done   = 1'b1;
          end else begin
            if (!nonempty_q) begin
              first_d    = step_byte_i;
              nonempty_d = 1'b1;
            end
            // x10 as two shifts; the digit is the low nibble
            if (step_byte_i >= ChZero && step_byte_i <= ChNine) begin
              acc_d = (acc_q << 3) + (acc_q << 1) + {28'd0, step_byte_i[3:0]};
            end
            commit = step_last_i;
          end
        end
        default: phase_d = phase_q;
      endcase
    end

    rec_commit = (commit && nonempty_d) ? apply_value(rec_q, key_q, acc_d, first_d)
                                        : rec_q;
    rec_d = rec_commit;
    emit  = step_valid_i && phase_q != PH_SKIP && (done || step_last_i);

    if (emit && !step_last_i) begin
      phase_d = PH_SKIP;
    end
    // any last byte returns the parser to its reset state
    if (step_valid_i && step_last_i) begin
      phase_d    = PH_KEY;
      key_d      = '0;
      acc_d      = '0;
      first_d    = '0;
      nonempty_d = 1'b0;
      pos_d      = '0;
      rec_d      = '0;
    end
  end

  assign rec_valid_o          = emit;
  assign rec_o.params         = rec_commit;
  assign rec_o.payload_start  = pos_d == '0 ? pos_next : pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_KEY;
      key_q      <= '0;
      acc_q      <= '0;
      first_q    <= '0;
      nonempty_q <= 1'b0;
      pos_q      <= '0;
      rec_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      key_q      <= key_d;
      acc_q      <= acc_d;
      first_q    <= first_d;
      nonempty_q <= nonempty_d;
      pos_q      <= pos_d;
      rec_q      <= rec_d;
    end
  end

endmodule

// ----- hdl/key_value_header_parser.sv -----
// Key/value header parser top level: input register, parser, result buffer.
// Takes one header byte per beat with a last flag, parses comma-separated
// "k=value" pairs up to the first ';' and sends one record of the eleven
// known parameters plus payload_start per command: at the ';', or at the
// last byte if no ';' came first. Bytes after the ';' are swallowed up to
// the last flag and produce nothing. Fields never set read 0. Throughput is
// one byte per clock while in_stall_o is low: each byte is parsed
// combinationally between the input register and the result buffer, the only
// dependency being the x10 accumulate of the parser state. An accepted byte is
// registered in the input register, its record in the result buffer. The buffer holds two
// records, so the input keeps flowing while one record waits on out_stall_i;
// in_stall_o rises only when both slots are full and a byte is waiting.
`include "key_value_header_parser_macros.svh"

module key_value_header_parser
  import kvhp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      header_byte_i,
  input  logic            final_byte_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      action_char_o,
  output logic [31:0]     format_code_o,
  output logic [31:0]     width_pixels_o,
  output logic [31:0]     height_pixels_o,
  output logic [31:0]     image_number_o,
  output logic [31:0]     more_chunks_o,
  output logic            zlib_flag_o,
  output logic [31:0]     quiet_level_o,
  output logic [31:0]     virtual_place_o,
  output logic [31:0]     place_columns_o,
  output logic [31:0]     place_rows_o,
  output logic [PosW-1:0] payload_start_o
);

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // two-entry result buffer: head drives the ports, skid catches overflow
  result_t head_q, head_d, skid_q, skid_d;
  logic    head_valid_q, head_valid_d, skid_valid_q, skid_valid_d;

  logic    room, consume, accept, pop;
  logic    rec_valid;
  result_t rec;

  // a byte may make a record, so it moves on only if a slot is free
  assign room       = !skid_valid_q;
  assign consume    = s1_valid_q && room;
  assign in_stall_o = s1_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = head_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (consume) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= header_byte_i;
      s1_last_q <= final_byte_i;
    end
  end

  kvhp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (consume),
    .step_byte_i  (s1_byte_q),
    .step_last_i  (s1_last_q),
    .rec_valid_o  (rec_valid),
    .rec_o        (rec)
  );

  always_comb begin
    head_d       = head_q;
    skid_d       = skid_q;
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    if (pop) begin
      if (skid_valid_q) begin
        head_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        head_valid_d = 1'b0;
      end
    end
    if (rec_valid) begin
      if (!head_valid_d) begin
        head_d       = rec;
        head_valid_d = 1'b1;
      end else begin
        skid_d       = rec;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = head_valid_q;
  assign action_char_o   = head_q.params.action_char;
  assign format_code_o   = head_q.params.format_code;
  assign width_pixels_o  = head_q.params.width_pixels;
  assign height_pixels_o = head_q.params.height_pixels;
  assign image_number_o  = head_q.params.image_number;
  assign more_chunks_o   = head_q.params.more_chunks;
  assign zlib_flag_o     = head_q.params.zlib_flag;
  assign quiet_level_o   = head_q.params.quiet_level;
  assign virtual_place_o = head_q.params.virtual_place;
  assign place_columns_o = head_q.params.place_columns;
  assign place_rows_o    = head_q.params.place_rows;
  assign payload_start_o = head_q.payload_start;

  // skid only ever fills behind a waiting head
  `KVHP_ASSERT(a_skid_behind_head, skid_valid_q |-> head_valid_q)
  // parser never hands over a record with both slots taken
  `KVHP_ASSERT(a_rec_has_room, rec_valid |-> !skid_valid_q)
  // draining a full buffer leaves the skid record at the head
  `KVHP_ASSERT(a_skid_moves_up,
    (head_valid_q && skid_valid_q && !out_stall_i) |=> (head_valid_q && !skid_valid_q))
  // a byte held back keeps its place in the input register
  `KVHP_ASSERT(a_s1_holds,
    (s1_valid_q && !consume) |=> (s1_valid_q && $stable(s1_byte_q) && $stable(s1_last_q)))

endmodule
